### hw/rtl/ped_pkg.sv
// shared constants, codes, gradient tables and arithmetic helpers for the particle step block
package ped_pkg;

	// fixed point formats
	localparam int FRAC_BITS = 16;
	localparam int COEF_BITS = 16;
	localparam logic [16:0] T_ONE = 17'h10000;

	// color normalization constants
	localparam logic [31:0] MASS_LOW  = 32'd10000000;
	localparam logic [34:0] MASS_SPAN = 35'd990000000;
	localparam logic [34:0] KE_DIV    = 35'd30517578125;
	localparam logic [34:0] AGE_DIV   = 35'd1000;

	// gradient select codes
	localparam logic GRAD_IR      = 1'b0;
	localparam logic GRAD_CLASSIC = 1'b1;

	// configuration register indexes
	typedef enum logic [3:0] {
		CFG_COLOR_MODE   = 4'd0,
		CFG_TIME_STEP    = 4'd1,
		CFG_DAMPING      = 4'd2,
		CFG_INTERVAL     = 4'd3,
		CFG_MAX_SPEED    = 4'd4,
		CFG_CENTRE_X     = 4'd5,
		CFG_CENTRE_Y     = 4'd6,
		CFG_GRAD_SELECT  = 4'd7
	} cfg_idx_t;

	// color source modes
	typedef enum logic [2:0] {
		MODE_SPEED = 3'd0,
		MODE_ACCEL = 3'd1,
		MODE_MASS  = 3'd2,
		MODE_KE    = 3'd3,
		MODE_DIST  = 3'd4,
		MODE_AGE   = 3'd5
	} mode_t;

	// saturate to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (x > hi) return 32'sh7fffffff;
		if (x < lo) return 32'sh80000000;
		return x[31:0];
	endfunction

	// product with a q0.16 coefficient, rounded half up
	function automatic logic signed [63:0] rnd_coef(input logic signed [63:0] p);
		logic signed [63:0] half;
		half = 64'sd1 <<< (COEF_BITS - 1);
		return (p + half) >>> COEF_BITS;
	endfunction

	// magnitude of a signed 32 bit value
	function automatic logic [31:0] uabs32(input logic signed [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	// gradient stop positions
	function automatic logic [16:0] grad_pos(input logic sel, input logic [2:0] k);
		logic [16:0] p;
		p = T_ONE;
		if (sel == GRAD_IR) begin
			unique case (k)
				3'd0: p = 17'd0;
				3'd1: p = 17'd9830;
				3'd2: p = 17'd19661;
				3'd3: p = 17'd29491;
				3'd4: p = 17'd39322;
				3'd5: p = 17'd49152;
				3'd6: p = 17'd58982;
				3'd7: p = 17'd65536;
			endcase
		end else begin
			unique case (k)
				3'd0: p = 17'd0;
				3'd1: p = 17'd16384;
				3'd2: p = 17'd32768;
				3'd3: p = 17'd49152;
				default: p = 17'd65536;
			endcase
		end
		return p;
	endfunction

	// gradient stop colors, index 0 red, 1 green, 2 blue
	function automatic logic [2:0][7:0] grad_rgb(input logic sel, input logic [2:0] k);
		logic [2:0][7:0] c;
		c = '0;
		if (sel == GRAD_IR) begin
			unique case (k)
				3'd0: c = {8'd0,   8'd0,   8'd51};
				3'd1: c = {8'd0,   8'd26,  8'd204};
				3'd2: c = {8'd0,   8'd102, 8'd255};
				3'd3: c = {8'd0,   8'd230, 8'd255};
				3'd4: c = {8'd255, 8'd204, 8'd0};
				3'd5: c = {8'd255, 8'd102, 8'd51};
				3'd6: c = {8'd255, 8'd51,  8'd128};
				3'd7: c = {8'd255, 8'd153, 8'd204};
			endcase
		end else begin
			unique case (k)
				3'd0: c = {8'd0,   8'd0,   8'd255};
				3'd1: c = {8'd0,   8'd255, 8'd255};
				3'd2: c = {8'd0,   8'd255, 8'd0};
				3'd3: c = {8'd255, 8'd0,   8'd0};
				default: c = {8'd204, 8'd0, 8'd255};
			endcase
		end
		return c;
	endfunction

	// upper stop index of the segment holding t
	function automatic logic [2:0] seg_sel(input logic sel, input logic [16:0] t);
		logic [2:0] i;
		logic [2:0] last;
		i = 3'd1;
		last = (sel == GRAD_IR) ? 3'd6 : 3'd3;
		for (int k = 1; k <= 6; k++) begin
			if (3'(k) <= last && t >= grad_pos(sel, 3'(k)))
				i = 3'(k + 1);
		end
		return i;
	endfunction

endpackage

### hw/rtl/ped_sqrt.sv
// pipelined integer square root, one root bit per stage, with side data carried along
module ped_sqrt #(
	parameter int RW = 64,
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [RW-1:0]       in_rad,
	input  logic [SW-1:0]       in_side,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RW/2-1:0]     out_root,
	output logic [SW-1:0]       out_side
);

	localparam int NST = RW / 2;

	logic          v_s    [NST];
	logic [RW-1:0] rem_s  [NST];
	logic [RW-1:0] root_s [NST];
	logic [SW-1:0] side_s [NST];
	logic          rdy    [NST+1];

	assign rdy[NST]  = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = v_s[NST-1];
	assign out_root  = root_s[NST-1][RW/2-1:0];
	assign out_side  = side_s[NST-1];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic          vi;
		logic [RW-1:0] rem_i, root_i, rem_o, root_o;
		logic [SW-1:0] side_i;

		if (k == 0) begin : g_first
			assign vi     = in_valid;
			assign rem_i  = in_rad;
			assign root_i = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign vi     = v_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = side_s[k-1];
		end

		// one trial subtraction of root plus the current bit
		always_comb begin
			logic [RW-1:0] bitv, trial;
			bitv  = RW'(1) << (RW - 2 - 2 * k);
			trial = root_i + bitv;
			if (rem_i >= trial) begin
				rem_o  = rem_i - trial;
				root_o = (root_i >> 1) + bitv;
			end else begin
				rem_o  = rem_i;
				root_o = root_i >> 1;
			end
		end

		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (rdy[k]) v_s[k] <= vi;
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vi) begin
				rem_s[k]  <= rem_o;
				root_s[k] <= root_o;
				side_s[k] <= side_i;
			end
		end
	end

endmodule

### hw/rtl/ped_div.sv
// pipelined restoring divider, one quotient bit per stage, several lanes sharing one valid
module ped_div #(
	parameter int LANES = 1,
	parameter int DW    = 35,
	parameter int QW    = 17,
	parameter int SW    = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [LANES-1:0][DW+QW-1:0]     in_num,
	input  logic [LANES-1:0][DW-1:0]        in_den,
	input  logic [SW-1:0]                   in_side,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [LANES-1:0][QW-1:0]        out_quo,
	output logic [SW-1:0]                   out_side
);

	localparam int NW = DW + QW;

	logic                        v_s    [QW];
	logic [LANES-1:0][NW-1:0]    rem_s  [QW];
	logic [LANES-1:0][DW-1:0]    den_s  [QW];
	logic [LANES-1:0][QW-1:0]    quo_s  [QW];
	logic [SW-1:0]               side_s [QW];
	logic                        rdy    [QW+1];

	assign rdy[QW]   = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = v_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                     vi;
		logic [LANES-1:0][NW-1:0] rem_i, rem_o;
		logic [LANES-1:0][DW-1:0] den_i;
		logic [LANES-1:0][QW-1:0] quo_i, quo_o;
		logic [SW-1:0]            side_i;

		if (k == 0) begin : g_first
			assign vi     = in_valid;
			assign rem_i  = in_num;
			assign den_i  = in_den;
			assign quo_i  = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign vi     = v_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign den_i  = den_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign side_i = side_s[k-1];
		end

		// compare against the shifted divisor and shift in one quotient bit
		always_comb begin
			logic [NW-1:0] shd;
			for (int l = 0; l < LANES; l++) begin
				shd = NW'(den_i[l]) << (QW - 1 - k);
				if (rem_i[l] >= shd) begin
					rem_o[l] = rem_i[l] - shd;
					quo_o[l] = {quo_i[l][QW-2:0], 1'b1};
				end else begin
					rem_o[l] = rem_i[l];
					quo_o[l] = {quo_i[l][QW-2:0], 1'b0};
				end
			end
		end

		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (rdy[k]) v_s[k] <= vi;
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vi) begin
				rem_s[k]  <= rem_o;
				den_s[k]  <= den_i;
				quo_s[k]  <= quo_o;
				side_s[k] <= side_i;
			end
		end
	end

endmodule

### hw/rtl/particle_euler_step_colormap.sv
// top level: damped euler particle step with gradient coloring
//
// One particle enters on the s_ stream and one result leaves on the m_ stream.
// Configuration is written through cfg_we / cfg_index / cfg_data while the
// block is idle; indexes past the last register are ignored.
// From input accept to m_tvalid an item passes the velocity, position and
// square-term stages s1 to s9, the root pipeline (one root bit per stage),
// the quotient-operand register s10, the divider (one quotient bit per
// stage), the gradient lookup stages s11 and s12, the color divider and the
// output register s13. Throughput is one item per cycle while m_tready
// stays high. Every stage carries a valid bit and loads when it is empty or
// the stage after it moves, so bubbles are squeezed out and a new item is
// taken as long as some stage is free, even while a result waits in the
// output register.
// When the receiver holds m_tready low, stages fill up behind the output and
// s_tready drops once the pipeline is full; nothing is lost or repeated.
// Reset empties the pipeline and loads every configuration register with its default.
module particle_euler_step_colormap (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// mass, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, age, frames_since_color,
	// old_red, old_green, old_blue
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_frames_since_color,
	// red, green, blue
	output logic [159:0] m_tdata
);

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic [7:0]         frames;
		logic               recolor;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} kin_t;

	typedef struct packed {
		logic [31:0] mass;
		logic [31:0] age;
	} aux_t;

	typedef struct packed {
		kin_t        kin;
		logic [63:0] n_pre;
		logic [34:0] den;
		logic        root_hi;
		logic        root_lo;
	} sq_side_t;

	typedef struct packed {
		kin_t kin;
		logic big;
	} dv_side_t;

	localparam int SQ_SW = $bits(sq_side_t);
	localparam int DV_SW = $bits(dv_side_t);
	localparam int GR_SW = $bits(kin_t);

	// configuration registers
	ped_pkg::mode_t     color_mode_q;
	logic [15:0]        time_step_q;
	logic [16:0]        damping_q;
	logic [7:0]         interval_q;
	logic [31:0]        max_speed_q;
	logic signed [31:0] centre_x_q;
	logic signed [31:0] centre_y_q;
	logic               grad_sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= ped_pkg::MODE_SPEED;
			time_step_q  <= 16'd1092;
			damping_q    <= 17'h10000;
			interval_q   <= 8'd0;
			max_speed_q  <= 32'h10000;
			centre_x_q   <= '0;
			centre_y_q   <= '0;
			grad_sel_q   <= ped_pkg::GRAD_IR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ped_pkg::CFG_COLOR_MODE:  color_mode_q <= ped_pkg::mode_t'(cfg_data[2:0]);
				ped_pkg::CFG_TIME_STEP:   time_step_q  <= cfg_data[15:0];
				ped_pkg::CFG_DAMPING:     damping_q    <= cfg_data[16:0];
				ped_pkg::CFG_INTERVAL:    interval_q   <= cfg_data[7:0];
				ped_pkg::CFG_MAX_SPEED:   max_speed_q  <= cfg_data;
				ped_pkg::CFG_CENTRE_X:    centre_x_q   <= cfg_data;
				ped_pkg::CFG_CENTRE_Y:    centre_y_q   <= cfg_data;
				ped_pkg::CFG_GRAD_SELECT: grad_sel_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input unpacking
	logic [31:0]        in_mass, in_age;
	logic signed [31:0] in_px, in_py, in_vx, in_vy, in_ax, in_ay;
	logic [7:0]         in_frames;

	assign in_mass   = s_tdata[31:0];
	assign in_px     = s_tdata[63:32];
	assign in_py     = s_tdata[95:64];
	assign in_vx     = s_tdata[127:96];
	assign in_vy     = s_tdata[159:128];
	assign in_ax     = s_tdata[191:160];
	assign in_ay     = s_tdata[223:192];
	assign in_age    = s_tdata[255:224];
	assign in_frames = s_tdata[263:256];

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9;
	logic rdy_s10, rdy_s11, rdy_s12, rdy_s13;
	logic sq_in_ready, sq_out_valid, md_in_ready, md_out_valid, gd_in_ready, gd_out_valid;

	assign rdy_s13  = !v_s13 || m_tready;
	assign rdy_s12  = !v_s12 || gd_in_ready;
	assign rdy_s11  = !v_s11 || rdy_s12;
	assign rdy_s10  = !v_s10 || md_in_ready;
	assign rdy_s9   = !v_s9 || sq_in_ready;
	assign rdy_s8   = !v_s8 || rdy_s9;
	assign rdy_s7   = !v_s7 || rdy_s8;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1  <= s_tvalid;
			if (rdy_s2)  v_s2  <= v_s1;
			if (rdy_s3)  v_s3  <= v_s2;
			if (rdy_s4)  v_s4  <= v_s3;
			if (rdy_s5)  v_s5  <= v_s4;
			if (rdy_s6)  v_s6  <= v_s5;
			if (rdy_s7)  v_s7  <= v_s6;
			if (rdy_s8)  v_s8  <= v_s7;
			if (rdy_s9)  v_s9  <= v_s8;
			if (rdy_s10) v_s10 <= sq_out_valid;
			if (rdy_s11) v_s11 <= md_out_valid;
			if (rdy_s12) v_s12 <= v_s11;
			if (rdy_s13) v_s13 <= gd_out_valid;
		end
	end

	// s1: acceleration times time step, frame counter
	kin_t               kin_s1;
	aux_t               aux_s1;
	logic signed [48:0] pax_s1, pay_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			pax_s1         <= $signed(in_ax) * $signed({1'b0, time_step_q});
			pay_s1         <= $signed(in_ay) * $signed({1'b0, time_step_q});
			kin_s1.px      <= in_px;
			kin_s1.py      <= in_py;
			kin_s1.vx      <= in_vx;
			kin_s1.vy      <= in_vy;
			kin_s1.recolor <= in_frames >= interval_q;
			if (in_frames >= interval_q) kin_s1.frames <= 8'd0;
			else if (in_frames == 8'hff) kin_s1.frames <= 8'hff;
			else kin_s1.frames <= in_frames + 8'd1;
			kin_s1.red     <= s_tdata[271:264];
			kin_s1.green   <= s_tdata[279:272];
			kin_s1.blue    <= s_tdata[287:280];
			aux_s1.mass    <= in_mass;
			aux_s1.age     <= in_age;
		end
	end

	// s2: velocity plus rounded acceleration term
	kin_t kin_s2, kin_d2;
	aux_t aux_s2;

	always_comb begin
		kin_d2    = kin_s1;
		kin_d2.vx = ped_pkg::sat32(64'(kin_s1.vx) + ped_pkg::rnd_coef(64'(pax_s1)));
		kin_d2.vy = ped_pkg::sat32(64'(kin_s1.vy) + ped_pkg::rnd_coef(64'(pay_s1)));
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			kin_s2 <= kin_d2;
			aux_s2 <= aux_s1;
		end
	end

	// s3: damping product
	kin_t               kin_s3;
	aux_t               aux_s3;
	logic signed [49:0] pdx_s3, pdy_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			pdx_s3 <= kin_s2.vx * $signed({1'b0, damping_q});
			pdy_s3 <= kin_s2.vy * $signed({1'b0, damping_q});
			kin_s3 <= kin_s2;
			aux_s3 <= aux_s2;
		end
	end

	// s4: new velocity
	kin_t kin_s4, kin_d4;
	aux_t aux_s4;

	always_comb begin
		kin_d4    = kin_s3;
		kin_d4.vx = ped_pkg::sat32(ped_pkg::rnd_coef(64'(pdx_s3)));
		kin_d4.vy = ped_pkg::sat32(ped_pkg::rnd_coef(64'(pdy_s3)));
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			kin_s4 <= kin_d4;
			aux_s4 <= aux_s3;
		end
	end

	// s5: velocity times time step, velocity squares
	kin_t               kin_s5;
	aux_t               aux_s5;
	logic signed [48:0] pvx_s5, pvy_s5;
	logic [63:0]        sqx_s5, sqy_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			pvx_s5 <= kin_s4.vx * $signed({1'b0, time_step_q});
			pvy_s5 <= kin_s4.vy * $signed({1'b0, time_step_q});
			sqx_s5 <= 64'(ped_pkg::uabs32(kin_s4.vx)) * 64'(ped_pkg::uabs32(kin_s4.vx));
			sqy_s5 <= 64'(ped_pkg::uabs32(kin_s4.vy)) * 64'(ped_pkg::uabs32(kin_s4.vy));
			kin_s5 <= kin_s4;
			aux_s5 <= aux_s4;
		end
	end

	// s6: new position, squared speed
	kin_t        kin_s6, kin_d6;
	aux_t        aux_s6;
	logic [63:0] ssq_s6;

	always_comb begin
		kin_d6    = kin_s5;
		kin_d6.px = ped_pkg::sat32(64'(kin_s5.px) + ped_pkg::rnd_coef(64'(pvx_s5)));
		kin_d6.py = ped_pkg::sat32(64'(kin_s5.py) + ped_pkg::rnd_coef(64'(pvy_s5)));
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			kin_s6 <= kin_d6;
			ssq_s6 <= sqx_s5 + sqy_s5;
			aux_s6 <= aux_s5;
		end
	end

	// s7: offset from the centre, kinetic energy partial products
	kin_t               kin_s7;
	aux_t               aux_s7;
	logic [63:0]        ssq_s7, kea_s7, keb_s7;
	logic signed [32:0] dx_s7, dy_s7;

	always_ff @(posedge clk) begin
		if (rdy_s7 && v_s6) begin
			dx_s7  <= 33'(kin_s6.px) - 33'(centre_x_q);
			dy_s7  <= 33'(kin_s6.py) - 33'(centre_y_q);
			kea_s7 <= 64'(aux_s6.mass) * 64'(ssq_s6[63:32]);
			keb_s7 <= 64'(aux_s6.mass) * 64'(ssq_s6[31:0]);
			ssq_s7 <= ssq_s6;
			kin_s7 <= kin_s6;
			aux_s7 <= aux_s6;
		end
	end

	// s8: distance squares, full energy product
	kin_t        kin_s8;
	aux_t        aux_s8;
	logic [63:0] ssq_s8;
	logic [95:0] kep_s8;
	logic [31:0] dsqx_s8, dsqy_s8;
	logic        far_s8;
	logic [32:0] adx, ady;

	assign adx = dx_s7[32] ? (~dx_s7 + 33'd1) : dx_s7;
	assign ady = dy_s7[32] ? (~dy_s7 + 33'd1) : dy_s7;

	always_ff @(posedge clk) begin
		if (rdy_s8 && v_s7) begin
			far_s8  <= (adx >= (33'd1 << ped_pkg::FRAC_BITS)) ||
			           (ady >= (33'd1 << ped_pkg::FRAC_BITS));
			dsqx_s8 <= 32'(adx[15:0]) * 32'(adx[15:0]);
			dsqy_s8 <= 32'(ady[15:0]) * 32'(ady[15:0]);
			kep_s8  <= {32'd0, keb_s7} + {kea_s7, 32'd0};
			ssq_s8  <= ssq_s7;
			kin_s8  <= kin_s7;
			aux_s8  <= aux_s7;
		end
	end

	// s9: root operand and per-mode quotient operands
	sq_side_t    side_d, side_s9;
	logic [63:0] rad_d, rad_s9;

	always_comb begin
		logic [32:0] dsq;
		dsq            = 33'(dsqx_s8) + 33'(dsqy_s8);
		side_d.kin     = kin_s8;
		side_d.n_pre   = '0;
		side_d.den     = 35'd1;
		side_d.root_hi = 1'b0;
		side_d.root_lo = 1'b0;
		rad_d          = (color_mode_q == ped_pkg::MODE_SPEED) ? ssq_s8 : 64'(dsq);
		unique case (color_mode_q)
			ped_pkg::MODE_SPEED: begin
				side_d.root_hi = 1'b1;
				side_d.den     = (max_speed_q == '0) ? 35'd1 : 35'(max_speed_q);
			end
			ped_pkg::MODE_MASS: begin
				if (aux_s8.mass > ped_pkg::MASS_LOW)
					side_d.n_pre = 64'(aux_s8.mass - ped_pkg::MASS_LOW) << 16;
				side_d.den = ped_pkg::MASS_SPAN;
			end
			ped_pkg::MODE_KE: begin
				side_d.n_pre = kep_s8[95:32];
				side_d.den   = ped_pkg::KE_DIV;
			end
			ped_pkg::MODE_DIST: begin
				// far from the centre saturates at the gradient end
				if (far_s8) side_d.n_pre = 64'(ped_pkg::T_ONE) << 1;
				else side_d.root_lo = 1'b1;
			end
			ped_pkg::MODE_AGE: begin
				side_d.n_pre = 64'(aux_s8.age);
				side_d.den   = ped_pkg::AGE_DIV;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s9 && v_s8) begin
			side_s9 <= side_d;
			rad_s9  <= rad_d;
		end
	end

	// root pipeline
	logic [31:0]      sq_root;
	logic [SQ_SW-1:0] sq_side_raw;
	sq_side_t         sq_side;

	ped_sqrt #(
		.RW (64),
		.SW (SQ_SW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.in_ready  (sq_in_ready),
		.in_rad    (rad_s9),
		.in_side   (side_s9),
		.out_valid (sq_out_valid),
		.out_ready (rdy_s10),
		.out_root  (sq_root),
		.out_side  (sq_side_raw)
	);

	assign sq_side = sq_side_raw;

	// s10: numerator select and saturation check
	logic [51:0] num_s10;
	logic [34:0] den_s10;
	dv_side_t    dvs_s10;

	always_ff @(posedge clk) begin
		logic [63:0] n_full;
		logic        big;
		if (sq_side.root_hi) n_full = {16'd0, sq_root, 16'd0};
		else if (sq_side.root_lo) n_full = {32'd0, sq_root};
		else n_full = sq_side.n_pre;
		big = n_full >= {12'd0, sq_side.den, 17'd0};
		if (rdy_s10 && sq_out_valid) begin
			num_s10     <= big ? '0 : n_full[51:0];
			den_s10     <= sq_side.den;
			dvs_s10.kin <= sq_side.kin;
			dvs_s10.big <= big;
		end
	end

	// normalizing divider
	logic [16:0]      md_quo;
	logic [DV_SW-1:0] md_side_raw;
	dv_side_t         md_side;

	ped_div #(
		.LANES (1),
		.DW    (35),
		.QW    (17),
		.SW    (DV_SW)
	) u_norm_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s10),
		.in_ready  (md_in_ready),
		.in_num    (num_s10),
		.in_den    (den_s10),
		.in_side   (dvs_s10),
		.out_valid (md_out_valid),
		.out_ready (rdy_s11),
		.out_quo   (md_quo),
		.out_side  (md_side_raw)
	);

	assign md_side = md_side_raw;

	// s11: clamp and gradient segment
	kin_t        kin_s11;
	logic [2:0]  seg_s11;
	logic [14:0] d_s11, span_s11;
	logic [16:0] t_c;
	logic [2:0]  seg_c;
	logic [16:0] plo_c, phi_c;

	always_comb begin
		if (md_side.big || md_quo > ped_pkg::T_ONE) t_c = ped_pkg::T_ONE;
		else t_c = md_quo;
		seg_c = ped_pkg::seg_sel(grad_sel_q, t_c);
		plo_c = ped_pkg::grad_pos(grad_sel_q, seg_c - 3'd1);
		phi_c = ped_pkg::grad_pos(grad_sel_q, seg_c);
	end

	always_ff @(posedge clk) begin
		if (rdy_s11 && md_out_valid) begin
			kin_s11  <= md_side.kin;
			seg_s11  <= seg_c;
			d_s11    <= 15'(t_c - plo_c);
			span_s11 <= 15'(phi_c - plo_c);
		end
	end

	// s12: interpolation numerators per channel
	kin_t                 kin_s12;
	logic [2:0][22:0]     num_s12;
	logic [2:0][14:0]     span_s12;
	logic [2:0][7:0]      c0, c1;

	assign c0 = ped_pkg::grad_rgb(grad_sel_q, seg_s11 - 3'd1);
	assign c1 = ped_pkg::grad_rgb(grad_sel_q, seg_s11);

	always_ff @(posedge clk) begin
		if (rdy_s12 && v_s11) begin
			for (int c = 0; c < 3; c++) begin
				num_s12[c]  <= 23'(c0[c]) * 23'(span_s11 - d_s11) + 23'(c1[c]) * 23'(d_s11) +
				               23'(span_s11 >> 1);
				span_s12[c] <= span_s11;
			end
			kin_s12 <= kin_s11;
		end
	end

	// color division by the segment span
	logic [2:0][7:0]  gd_quo;
	logic [GR_SW-1:0] gd_side_raw;
	kin_t             gd_kin;

	ped_div #(
		.LANES (3),
		.DW    (15),
		.QW    (8),
		.SW    (GR_SW)
	) u_color_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s12),
		.in_ready  (gd_in_ready),
		.in_num    (num_s12),
		.in_den    (span_s12),
		.in_side   (kin_s12),
		.out_valid (gd_out_valid),
		.out_ready (rdy_s13),
		.out_quo   (gd_quo),
		.out_side  (gd_side_raw)
	);

	assign gd_kin = gd_side_raw;

	// s13: output register, old color kept when not recolored
	kin_t kin_s13, kin_d13;

	always_comb begin
		kin_d13 = gd_kin;
		if (gd_kin.recolor) begin
			kin_d13.red   = gd_quo[0];
			kin_d13.green = gd_quo[1];
			kin_d13.blue  = gd_quo[2];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s13 && gd_out_valid) kin_s13 <= kin_d13;
	end

	assign m_tvalid = v_s13;
	assign m_tdata  = {kin_s13.blue, kin_s13.green, kin_s13.red, kin_s13.frames,
	                   kin_s13.vy, kin_s13.vx, kin_s13.py, kin_s13.px};

	// an empty output register means every stage can move
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output register");

	// interpolation offset never passes the segment span
	a_offset_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		v_s11 |-> d_s11 <= span_s11)
		else $error("gradient offset beyond segment span");

	// segment index stays inside the selected gradient
	a_segment_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s11 |-> seg_s11 >= 3'd1 &&
		((grad_sel_q == ped_pkg::GRAD_IR && seg_s11 <= 3'd7) ||
		 (grad_sel_q == ped_pkg::GRAD_CLASSIC && seg_s11 <= 3'd4)))
		else $error("gradient segment out of range");

endmodule
